/* rtl/core/ir_pulse_frame_capture_core_defines.svh */
`ifndef IR_PULSE_FRAME_CAPTURE_CORE_DEFINES_SVH
`define IR_PULSE_FRAME_CAPTURE_CORE_DEFINES_SVH

// same-cycle implication
`define IPFC_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define IPFC_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/ipfc_pkg.sv */
package ipfc_pkg;

  localparam int BYTE_W = 8;

  localparam logic [15:0] NEW_FRAME_GAP_RESET = 16'd5000;
  localparam logic [15:0] ONE_BIT_THRESHOLD_RESET = 16'd600;

  localparam logic [1:0] CFG_NEW_FRAME_GAP = 2'd0;
  localparam logic [1:0] CFG_ONE_BIT_THRESHOLD = 2'd1;

  typedef enum logic [1:0] {
    OP_EDGE    = 2'd0,
    OP_SILENCE = 2'd1,
    OP_READ    = 2'd2,
    OP_IDLE    = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_DATA     = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_TOO_LONG = 3'd2,
    ST_STORED   = 3'd3,
    ST_DROPPED  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CP_RD,
    S_CP_WR,
    S_HEAD_RD,
    S_HEAD_CHK,
    S_LEN_TEST,
    S_SCAN_CHK,
    S_EMIT_RD,
    S_EMIT_OUT,
    S_RESP
  } state_t;

  typedef struct packed {
    logic    latch_in;
    logic    edge_ev;
    logic    clear_capture;
    logic    copy_start;
    logic    copy_write;
    logic    copy_next;
    logic    copy_done;
    logic    cnt_clear;
    logic    cnt_set1;
    logic    cnt_inc;
    logic    latch_len;
    logic    pop;
    logic    load_out;
    logic    out_data_sel;
    status_t out_code;
    logic    out_last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic fits;
    logic copy_last;
    logic limit_zero;
    logic fill_zero;
    logic q_mark;
    logic cnt_ge_fill;
    logic cnt_over;
    logic emit_last;
    logic out_free;
  } dp_stat_t;

endpackage

/* rtl/core/ipfc_ram.sv */
module ipfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/ipfc_ctrl.sv */
module ipfc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           opcode,
  input  ipfc_pkg::dp_stat_t   stat,
  output ipfc_pkg::ctrl_cmd_t  cmd
);

  import ipfc_pkg::*;

  state_t  state, state_next;
  status_t resp, resp_next;
  opcode_t op;
  logic    in_fire;

  assign op       = opcode_t'(opcode);
  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      resp  <= ST_EMPTY;
    end else begin
      state <= state_next;
      resp  <= resp_next;
    end
  end

  always_comb begin
    state_next = state;
    resp_next  = resp;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          case (op)
            OP_SILENCE: begin
              if (!stat.count_zero) begin
                if (stat.fits) begin
                  state_next = S_CP_RD;
                end else begin
                  resp_next  = ST_DROPPED;
                  state_next = S_RESP;
                end
              end
            end
            OP_READ: state_next = S_HEAD_RD;
            default: ;
          endcase
        end
      end
      S_CP_RD: state_next = S_CP_WR;
      S_CP_WR: begin
        if (stat.copy_last) begin
          resp_next  = ST_STORED;
          state_next = S_RESP;
        end else begin
          state_next = S_CP_RD;
        end
      end
      S_HEAD_RD: begin
        if (stat.limit_zero || stat.fill_zero) begin
          resp_next  = ST_EMPTY;
          state_next = S_RESP;
        end else begin
          state_next = S_HEAD_CHK;
        end
      end
      S_HEAD_CHK: begin
        if (!stat.q_mark) begin
          resp_next  = ST_EMPTY;
          state_next = S_RESP;
        end else begin
          state_next = S_LEN_TEST;
        end
      end
      S_LEN_TEST: begin
        // length already past what the reader takes: no need to finish the scan
        if (stat.cnt_over) begin
          resp_next  = ST_TOO_LONG;
          state_next = S_RESP;
        end else if (stat.cnt_ge_fill) begin
          state_next = S_EMIT_RD;
        end else begin
          state_next = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (stat.q_mark) begin
          state_next = S_EMIT_RD;
        end else begin
          state_next = S_LEN_TEST;
        end
      end
      S_EMIT_RD: state_next = S_EMIT_OUT;
      S_EMIT_OUT: begin
        if (stat.out_free) begin
          state_next = stat.emit_last ? S_IDLE : S_EMIT_RD;
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.out_code = ST_DATA;
    case (state)
      S_IDLE: begin
        cmd.latch_in = in_fire;
        if (in_fire) begin
          case (op)
            OP_EDGE: cmd.edge_ev = 1'b1;
            OP_SILENCE: begin
              if (!stat.count_zero) begin
                cmd.copy_start    = stat.fits;
                cmd.clear_capture = !stat.fits;
              end
            end
            OP_READ: cmd.cnt_clear = 1'b1;
            default: ;
          endcase
        end
      end
      S_CP_WR: begin
        cmd.copy_write = 1'b1;
        cmd.copy_done  = stat.copy_last;
        cmd.copy_next  = !stat.copy_last;
      end
      S_HEAD_CHK: cmd.cnt_set1 = stat.q_mark;
      S_LEN_TEST: cmd.latch_len = !stat.cnt_over && stat.cnt_ge_fill;
      S_SCAN_CHK: begin
        cmd.latch_len = stat.q_mark;
        cmd.cnt_inc   = !stat.q_mark;
      end
      S_EMIT_OUT: begin
        if (stat.out_free) begin
          cmd.load_out     = 1'b1;
          cmd.out_data_sel = 1'b1;
          cmd.out_code     = ST_DATA;
          cmd.out_last     = stat.emit_last;
          cmd.pop          = stat.emit_last;
          cmd.cnt_inc      = !stat.emit_last;
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_code = resp;
          cmd.out_last = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

/* rtl/core/ipfc_datapath.sv */
`include "ir_pulse_frame_capture_core_defines.svh"

module ipfc_datapath #(
  parameter int CAPTURE_BYTES = 64,
  parameter int QUEUE_DEPTH   = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ipfc_pkg::ctrl_cmd_t  cmd,
  output ipfc_pkg::dp_stat_t   stat,
  input  logic [15:0]          interval_us,
  input  logic [7:0]           read_limit,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           data_byte,
  output logic [2:0]           status,
  output logic                 last
);

  import ipfc_pkg::*;

  localparam int CAW = $clog2(CAPTURE_BYTES);
  localparam int CIW = $clog2(CAPTURE_BYTES + 1);
  localparam int QAW = $clog2(QUEUE_DEPTH);
  localparam int FW  = $clog2(QUEUE_DEPTH + 1);
  localparam int MW  = (FW > CIW) ? FW : CIW;
  localparam int OW  = ((MW > BYTE_W) ? MW : BYTE_W) + 1;

  // config
  logic [15:0] new_frame_gap;
  logic [15:0] one_bit_threshold;

  // capture side
  logic [7:0]     assembling;
  logic [2:0]     bit_pos;
  logic [CIW-1:0] count;
  logic [7:0]     assembling_next;
  logic [2:0]     bit_pos_next;
  logic [CIW-1:0] count_next;

  // queue side
  logic [QAW-1:0] head;
  logic [FW-1:0]  fill;
  logic [FW-1:0]  cnt;
  logic [FW-1:0]  len;
  logic [CIW-1:0] cidx;
  logic [7:0]     limit;

  logic [CIW-1:0] slen;
  logic [7:0]     cap_rdata;
  logic [8:0]     q_rdata;
  logic           cap_we;
  logic [CAW-1:0] cap_waddr;
  logic [7:0]     cap_wdata;
  logic [QAW-1:0] q_waddr;
  logic [8:0]     q_wdata;
  logic [QAW-1:0] q_raddr;

  // edge decode
  logic           gap_clear;
  logic [7:0]     a0, a1;
  logic [2:0]     b0;
  logic [CIW-1:0] c0;
  logic           cap_full;

  status_t out_status;

  function automatic logic [QAW-1:0] wrap_addr(input logic [OW-1:0] sum);
    logic [OW-1:0] t;
    t = (sum >= OW'(QUEUE_DEPTH)) ? sum - OW'(QUEUE_DEPTH) : sum;
    return t[QAW-1:0];
  endfunction

  ipfc_ram #(.WIDTH(8), .DEPTH(CAPTURE_BYTES)) u_cap_ram (
    .clk   (clk),
    .we    (cap_we),
    .waddr (cap_waddr),
    .wdata (cap_wdata),
    .raddr (cidx[CAW-1:0]),
    .rdata (cap_rdata)
  );

  ipfc_ram #(.WIDTH(9), .DEPTH(QUEUE_DEPTH)) u_queue_ram (
    .clk   (clk),
    .we    (cmd.copy_write),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  // edge event: gap check first, then one bit into the byte being built
  always_comb begin
    gap_clear = interval_us > new_frame_gap;
    a0        = gap_clear ? 8'd0 : assembling;
    b0        = gap_clear ? 3'd0 : bit_pos;
    c0        = gap_clear ? '0 : count;
    cap_full  = c0 >= CIW'(CAPTURE_BYTES);
    a1        = (interval_us > one_bit_threshold) ? (a0 | (8'd1 << b0)) : a0;
    cap_we    = cmd.edge_ev && !cap_full && (b0 == 3'd7);
    cap_waddr = c0[CAW-1:0];
    cap_wdata = a1;
  end

  always_comb begin
    assembling_next = assembling;
    bit_pos_next    = bit_pos;
    count_next      = count;
    if (cmd.clear_capture || cmd.copy_done) begin
      assembling_next = '0;
      bit_pos_next    = '0;
      count_next      = '0;
    end else if (cmd.edge_ev) begin
      if (cap_full) begin
        assembling_next = a0;
        bit_pos_next    = b0;
        count_next      = c0;
      end else if (b0 == 3'd7) begin
        assembling_next = '0;
        bit_pos_next    = '0;
        count_next      = c0 + CIW'(1);
      end else begin
        assembling_next = a1;
        bit_pos_next    = b0 + 3'd1;
        count_next      = c0;
      end
    end
  end

  // closed frame carries its partial byte unless the capture is full
  assign slen    = (count < CIW'(CAPTURE_BYTES)) ? count + CIW'(1) : count;
  assign q_waddr = wrap_addr(OW'(head) + OW'(fill) + OW'(cidx));
  assign q_wdata = {(cidx == '0), ((cidx < count) ? cap_rdata : assembling)};
  assign q_raddr = wrap_addr(OW'(head) + OW'(cnt));

  always_comb begin
    stat.count_zero  = (count == '0);
    stat.fits        = (OW'(fill) + OW'(slen)) < OW'(QUEUE_DEPTH);
    stat.copy_last   = (cidx + CIW'(1)) == slen;
    stat.limit_zero  = (limit == 8'd0);
    stat.fill_zero   = (fill == '0);
    stat.q_mark      = q_rdata[8];
    stat.cnt_ge_fill = cnt >= fill;
    stat.cnt_over    = (OW'(cnt) > OW'(limit)) || (OW'(cnt) > OW'(CAPTURE_BYTES));
    stat.emit_last   = (OW'(cnt) + OW'(1)) == OW'(len);
    stat.out_free    = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      new_frame_gap     <= NEW_FRAME_GAP_RESET;
      one_bit_threshold <= ONE_BIT_THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_NEW_FRAME_GAP:     new_frame_gap     <= cfg_data;
        CFG_ONE_BIT_THRESHOLD: one_bit_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      assembling <= '0;
      bit_pos    <= '0;
      count      <= '0;
      head       <= '0;
      fill       <= '0;
      out_valid  <= 1'b0;
    end else begin
      assembling <= assembling_next;
      bit_pos    <= bit_pos_next;
      count      <= count_next;
      if (cmd.copy_done) begin
        fill <= FW'(OW'(fill) + OW'(slen));
      end else if (cmd.pop) begin
        fill <= fill - len;
        head <= wrap_addr(OW'(head) + OW'(len));
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      limit <= read_limit;
    end
    if (cmd.copy_start) begin
      cidx <= '0;
    end else if (cmd.copy_next) begin
      cidx <= cidx + CIW'(1);
    end
    if (cmd.cnt_clear || cmd.latch_len) begin
      cnt <= '0;
    end else if (cmd.cnt_set1) begin
      cnt <= FW'(1);
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + FW'(1);
    end
    if (cmd.latch_len) begin
      len <= cnt;
    end
    if (cmd.load_out) begin
      data_byte  <= cmd.out_data_sel ? q_rdata[7:0] : 8'd0;
      out_status <= cmd.out_code;
      last       <= cmd.out_last;
    end
  end

  assign status = out_status;

  `IPFC_ASSERT_IMP(a_fill_bound, clk, rst, 1'b1, OW'(fill) < OW'(QUEUE_DEPTH), "queue fill reached depth")
  `IPFC_ASSERT_IMP(a_pop_len, clk, rst, cmd.pop, (len != '0) && (len <= fill), "pop length out of range")
  `IPFC_ASSERT_IMP(a_copy_fits, clk, rst, cmd.copy_write, stat.fits, "frame copy without room")
  `IPFC_ASSERT_NXT(a_copy_clears, clk, rst, cmd.copy_done, (count == '0) && (fill != '0), "store did not commit")

endmodule

/* rtl/core/ir_pulse_frame_capture_core.sv */
// Pulse-distance IR framer.
// Input channel (in_valid/in_ready): one word per event: opcode 0 edge with interval_us,
// 1 silence timeout, 2 read one frame limited to read_limit bytes, 3 ignored.
// Output channel (out_valid/out_ready): data_byte, status, last; last marks the final
// word caused by an input. Edges and empty silences produce no word.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 new-frame gap, 1 one-bit
// threshold, 16-bit data; write only while the block is idle.
// An edge is taken while idle. A silence copies each byte of a stored frame through a
// read and a write state, then sends the status word; a dropped frame sends only the
// status word. A read scans the queue to find the length (stops once it exceeds the
// limit), then streams each byte through a read and an output state; the pace is set
// by the single registered read port of the queue memory. in_ready is high only between
// items; the output register frees the input side as soon as the last word is loaded.
// Reset clears capture state, queue head and fill and the config registers to 5000/600;
// no memory clearing pass. A stalled receiver holds the output register and the
// sequencer waits on it.
module ir_pulse_frame_capture_core #(
  parameter int CAPTURE_BYTES = 64,
  parameter int QUEUE_DEPTH   = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [15:0] interval_us,
  input  logic [7:0]  read_limit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  data_byte,
  output logic [2:0]  status,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  import ipfc_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  ipfc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .opcode   (opcode),
    .stat     (stat),
    .cmd      (cmd)
  );

  ipfc_datapath #(
    .CAPTURE_BYTES (CAPTURE_BYTES),
    .QUEUE_DEPTH   (QUEUE_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .interval_us (interval_us),
    .read_limit  (read_limit),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .data_byte   (data_byte),
    .status      (status),
    .last        (last)
  );

endmodule
